>>> rtl/ptrle_pkg.sv
package ptrle_pkg;

    // Field widths of the request and result channels
    localparam int BYTE_W    = 8;
    localparam int CHANNEL_W = 2;
    localparam int START_W   = 12;
    localparam int LENGTH_W  = 13;
    localparam int COUNT_W   = 16;

    // Configuration register widths
    localparam int CFG_SIDE_W  = 7;
    localparam int CFG_PLANE_W = 3;

    // Defaults for the top-level parameters
    localparam int DEF_TILE_SIDE  = 64;
    localparam int DEF_MAX_PLANES = 4;

    // Register reset values
    localparam logic [CFG_SIDE_W-1:0]  RST_TILE_WIDTH  = 7'd64;
    localparam logic [CFG_SIDE_W-1:0]  RST_TILE_HEIGHT = 7'd64;
    localparam logic [CFG_PLANE_W-1:0] RST_BPP         = 3'd4;

    // Register word indexes (byte address / 4)
    localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BPP         = 2'd2;

    // Opcodes with a 16-bit count following
    localparam logic [BYTE_W-1:0] OP_LONG_REPEAT  = 8'd127;
    localparam logic [BYTE_W-1:0] OP_LONG_LITERAL = 8'd128;

    // Decoder phases
    typedef enum logic [5:0] {
        PH_OPCODE   = 6'b000001,
        PH_COUNT_HI = 6'b000010,
        PH_COUNT_LO = 6'b000100,
        PH_VALUE    = 6'b001000,
        PH_LITERAL  = 6'b010000,
        PH_DISCARD  = 6'b100000
    } phase_t;

    // One decoded run
    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [START_W-1:0]   start_pixel;
        logic [LENGTH_W-1:0]  run_length;
        logic [BYTE_W-1:0]    fill_value;
        logic                 overrun;
        logic                 tile_done;
    } run_t;

endpackage

>>> rtl/planar_tile_rle_decoder_core.sv
// Channel    | Direction | Handshake          | Payload
// -----------+-----------+--------------------+-----------------------------------------
// s_         | in        | s_valid / s_ready  | s_data_byte
// m_         | out       | m_valid / m_ready  | m_channel, m_start_pixel, m_run_length,
//            |           |                    | m_fill_value, m_overrun, m_tile_done
// APB        | in        | psel/penable/pready| tile_width, tile_height, bytes_per_pixel
//
// One byte is taken per cycle while s_ready is high; each byte is decoded in the cycle it is
// accepted and its run, if any, is registered into the output queue behind any runs waiting there.
// A two-entry output queue lets bytes keep flowing while the result side stalls;
// s_ready drops only when both entries hold runs.
// Reset (synchronous, aresetn low) loads the register defaults and restarts the tile.
// A write to any of the three registers also restarts the tile at plane 0, pixel 0.
module planar_tile_rle_decoder_core
    import ptrle_pkg::*;
#(
    parameter int TILE_SIDE  = DEF_TILE_SIDE,
    parameter int MAX_PLANES = DEF_MAX_PLANES
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHANNEL_W-1:0] m_channel,
    output logic [START_W-1:0]   m_start_pixel,
    output logic [LENGTH_W-1:0]  m_run_length,
    output logic [BYTE_W-1:0]    m_fill_value,
    output logic                 m_overrun,
    output logic                 m_tile_done
);

    localparam int SIDE_W     = $clog2(TILE_SIDE + 1);
    localparam int SIZE_W     = $clog2(TILE_SIDE * TILE_SIDE + 1);
    localparam int LEN_W      = (SIZE_W > COUNT_W) ? SIZE_W : COUNT_W;
    localparam int FIFO_DEPTH = 2;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        begin
            if (v == '0)
                r = SIDE_W'(1);
            else if (int'(v) > TILE_SIDE)
                r = SIDE_W'(TILE_SIDE);
            else
                r = SIDE_W'(v);
            return r;
        end
    endfunction

    function automatic logic [SIZE_W-1:0] plane_size(input logic [CFG_SIDE_W-1:0] w,
                                                     input logic [CFG_SIDE_W-1:0] h);
        logic [SIZE_W-1:0] a;
        logic [SIZE_W-1:0] b;
        begin
            a = SIZE_W'(clamp_side(w));
            b = SIZE_W'(clamp_side(h));
            return a * b;
        end
    endfunction

    function automatic logic [CFG_PLANE_W-1:0] clamp_planes(input logic [CFG_PLANE_W-1:0] v);
        logic [CFG_PLANE_W-1:0] r;
        begin
            if (v == '0)
                r = CFG_PLANE_W'(1);
            else if (int'(v) > MAX_PLANES)
                r = CFG_PLANE_W'(MAX_PLANES);
            else
                r = v;
            return r;
        end
    endfunction

    // Configuration registers
    logic [CFG_SIDE_W-1:0]  width_reg, width_next;
    logic [CFG_SIDE_W-1:0]  height_reg, height_next;
    logic [CFG_PLANE_W-1:0] bpp_reg, bpp_next;
    logic [SIZE_W-1:0]      plane_size_reg;
    logic [CFG_PLANE_W-1:0] plane_cnt_reg;
    logic                   cfg_we;
    logic                   cfg_hit;

    // Decoder state
    phase_t                 phase_reg, phase_next;
    logic [COUNT_W-1:0]     pend_reg, pend_next;
    logic                   rep_reg, rep_next;
    logic [BYTE_W-1:0]      hi_reg, hi_next;
    logic [CHANNEL_W-1:0]   plane_reg, plane_next;
    logic [SIZE_W-1:0]      pos_reg, pos_next;

    // Run arithmetic
    logic [LEN_W-1:0]       remaining;
    logic [LEN_W-1:0]       emit_len;
    logic [LEN_W-1:0]       run_len;
    logic                   ended;
    logic                   clip;
    logic [SIZE_W-1:0]      pos_adv;
    logic [CHANNEL_W:0]     plane_inc;
    logic                   last_plane;
    logic [CHANNEL_W-1:0]   plane_adv;
    logic [COUNT_W-1:0]     pend_dec;
    logic [COUNT_W-1:0]     long_count;

    logic                   s_fire;
    logic                   res_valid;
    run_t                   res_run;

    // Output queue
    run_t                   fifo_mem [FIFO_DEPTH];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             count_reg;
    logic                   push;
    logic                   pop;
    run_t                   head_run;

    // Register file access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign cfg_hit = cfg_we && (paddr[3:2] == REG_TILE_WIDTH || paddr[3:2] == REG_TILE_HEIGHT
                                || paddr[3:2] == REG_BPP);

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        if (cfg_we) begin
            unique case (paddr[3:2])
                REG_TILE_WIDTH:  width_next  = pwdata[CFG_SIDE_W-1:0];
                REG_TILE_HEIGHT: height_next = pwdata[CFG_SIDE_W-1:0];
                REG_BPP:         bpp_next    = pwdata[CFG_PLANE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TILE_WIDTH:  prdata = 32'(width_reg);
            REG_TILE_HEIGHT: prdata = 32'(height_reg);
            REG_BPP:         prdata = 32'(bpp_reg);
            default:         prdata = '0;
        endcase
    end

    // Latch registers and the derived plane geometry on each write to one of the three registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= RST_TILE_WIDTH;
            height_reg     <= RST_TILE_HEIGHT;
            bpp_reg        <= RST_BPP;
            plane_size_reg <= plane_size(RST_TILE_WIDTH, RST_TILE_HEIGHT);
            plane_cnt_reg  <= clamp_planes(RST_BPP);
        end else if (cfg_hit) begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            bpp_reg        <= bpp_next;
            plane_size_reg <= plane_size(width_next, height_next);
            plane_cnt_reg  <= clamp_planes(bpp_next);
        end
    end

    // Run placement: clip at plane end and advance position and plane
    assign s_fire     = s_valid && s_ready;
    assign remaining  = (pos_reg < plane_size_reg) ?
                        (LEN_W'(plane_size_reg) - LEN_W'(pos_reg)) : '0;
    assign emit_len   = (phase_reg == PH_LITERAL) ? LEN_W'(1) : LEN_W'(pend_reg);
    assign ended      = emit_len >= remaining;
    assign clip       = emit_len > remaining;
    assign run_len    = clip ? remaining : emit_len;
    assign pos_adv    = ended ? '0 : (pos_reg + SIZE_W'(emit_len));
    assign plane_inc  = {1'b0, plane_reg} + (CHANNEL_W + 1)'(1);
    assign last_plane = CFG_PLANE_W'(plane_inc) >= plane_cnt_reg;
    assign plane_adv  = ended ? (last_plane ? '0 : plane_inc[CHANNEL_W-1:0]) : plane_reg;
    assign pend_dec   = (pend_reg == '0) ? '0 : (pend_reg - COUNT_W'(1));
    assign long_count = {hi_reg, s_data_byte};

    // Decode one byte
    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        rep_next   = rep_reg;
        hi_next    = hi_reg;
        plane_next = plane_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;

        res_run.channel     = plane_reg;
        res_run.start_pixel = START_W'(pos_reg);
        res_run.run_length  = LENGTH_W'(run_len);
        res_run.fill_value  = s_data_byte;
        res_run.overrun     = clip;
        res_run.tile_done   = ended && last_plane;

        unique case (phase_reg)
            PH_COUNT_HI: begin
                hi_next    = s_data_byte;
                phase_next = PH_COUNT_LO;
            end
            PH_COUNT_LO: begin
                pend_next = long_count;
                if (rep_reg)
                    phase_next = PH_VALUE;
                else if (long_count == '0)
                    phase_next = PH_OPCODE;
                else
                    phase_next = PH_LITERAL;
            end
            PH_VALUE: begin
                phase_next = PH_OPCODE;
                if (pend_reg != '0) begin
                    res_valid  = 1'b1;
                    pos_next   = pos_adv;
                    plane_next = plane_adv;
                    pend_next  = '0;
                end
            end
            PH_LITERAL: begin
                res_valid       = 1'b1;
                pend_next       = pend_dec;
                pos_next        = pos_adv;
                plane_next      = plane_adv;
                res_run.overrun = clip || (ended && pend_dec != '0);
                if (ended && pend_dec != '0)
                    phase_next = PH_DISCARD;
                else if (pend_dec == '0)
                    phase_next = PH_OPCODE;
            end
            PH_DISCARD: begin
                pend_next = pend_dec;
                if (pend_dec == '0)
                    phase_next = PH_OPCODE;
            end
            default: begin
                if (s_data_byte < OP_LONG_REPEAT) begin
                    pend_next  = COUNT_W'(s_data_byte) + COUNT_W'(1);
                    rep_next   = 1'b1;
                    phase_next = PH_VALUE;
                end else if (s_data_byte == OP_LONG_REPEAT) begin
                    rep_next   = 1'b1;
                    phase_next = PH_COUNT_HI;
                end else if (s_data_byte == OP_LONG_LITERAL) begin
                    rep_next   = 1'b0;
                    phase_next = PH_COUNT_HI;
                end else begin
                    pend_next  = COUNT_W'(9'd256 - {1'b0, s_data_byte});
                    rep_next   = 1'b0;
                    phase_next = PH_LITERAL;
                end
            end
        endcase
    end

    // Hold decoder state; restart on reset or register write
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            phase_reg <= PH_OPCODE;
            pend_reg  <= '0;
            rep_reg   <= 1'b0;
            hi_reg    <= '0;
            plane_reg <= '0;
            pos_reg   <= '0;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            rep_reg   <= rep_next;
            hi_reg    <= hi_next;
            plane_reg <= plane_next;
            pos_reg   <= pos_next;
        end
    end

    // Output queue: push decoded runs, drop on result handshake
    assign push    = s_fire && res_valid;
    assign pop     = m_valid && m_ready;
    assign s_ready = count_reg != 2'(FIFO_DEPTH);
    assign m_valid = count_reg != '0;

    always_ff @(posedge aclk) begin
        if (push)
            fifo_mem[wr_ptr_reg] <= res_run;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    assign head_run      = fifo_mem[rd_ptr_reg];
    assign m_channel     = head_run.channel;
    assign m_start_pixel = head_run.start_pixel;
    assign m_run_length  = head_run.run_length;
    assign m_fill_value  = head_run.fill_value;
    assign m_overrun     = head_run.overrun;
    assign m_tile_done   = head_run.tile_done;

`ifndef NO_ASSERTIONS
    a_pos_in_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < plane_size_reg)
        else $error("pixel position outside plane");

    a_plane_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CFG_PLANE_W'(plane_reg) < plane_cnt_reg)
        else $error("plane index beyond plane count");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (phase_reg == PH_OPCODE && pos_reg == '0 && plane_reg == '0))
        else $error("register write did not restart tile");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not track push");

    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'(FIFO_DEPTH)) |-> !s_ready)
        else $error("request accepted with queue full");
`endif

endmodule
